// ===== rtl/thi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package thi_pkg;

  // Grid geometry.
  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 8;
  localparam int DIM_W      = 9;
  localparam int CODE_W     = 8;

  // The grid is split into four banks by column and row parity, so the four
  // corners of any grid square fall into four different banks.
  localparam int NUM_BANKS  = 4;
  localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Query arithmetic.
  localparam int POINT_W     = 15;
  localparam int TILE_W      = 9;
  localparam int FRAC_W      = 7;
  localparam int SPACING     = 100;
  localparam int CODE_ZERO   = 128;
  localparam int CM_PER_CODE = 10;
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = POINT_W + 13;
  localparam int HEIGHT_W    = 17;

  // Commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [CODE_W-1:0]  height_code;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic                sample_valid;
    logic [HEIGHT_W-1:0] height_hundredths;
  } result_t;

  // Query state travelling alongside the bank read data.
  typedef struct packed {
    logic              vld;
    logic              in_range;
    logic              tx_odd;
    logic              ty_odd;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } lookup_t;

  typedef logic [NUM_BANKS-1:0][BANK_AW-1:0] bank_addr_t;
  typedef logic [NUM_BANKS-1:0][CODE_W-1:0]  bank_data_t;

endpackage

`default_nettype wire

// ===== rtl/terrain_height_interpolator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Terrain height interpolator.
// Items are offered on item_i with start; an item is transferred at a rising
// edge where start is high and busy is low. busy is never raised, so one item
// may be transferred in every cycle. A write item stores one height code in
// the grid and gives no result. A query item gives exactly one result on
// result_o, marked by result_valid_o for a single cycle: the result passes the
// front-end register, the bank read and the interpolation stages and is taken at
// the edge that ends that cycle. Throughput is one item per cycle, set by the
// four grid banks, each of which serves one corner read and one write a cycle.
// Results cannot be held off by the receiver, so the pipeline never stalls.
// grid_width and grid_height are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must do so only while no query is in flight, which the
// block does not enforce. Reset clears both registers and the pipeline; the
// grid contents are undefined until written, and no clearing pass runs. A
// query reads the banks in the cycle after its transfer; a write transferred in
// that cycle lands after the read, so a query sees exactly the writes before it.
module terrain_height_interpolator_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire thi_pkg::item_t                item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [thi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [thi_pkg::DIM_W-1:0]     cfg_wdata_i,
  output      logic                          result_valid_o,
  output      thi_pkg::result_t              result_o
);

  logic [thi_pkg::DIM_W-1:0] grid_width_q, grid_height_q;

  logic                            accept;
  logic                            query_acc;
  logic                            write_acc;
  logic [thi_pkg::NUM_BANKS-1:0]   bank_we;
  logic [thi_pkg::BANK_AW-1:0]     wr_addr;
  logic                            rd_en;
  thi_pkg::bank_addr_t             rd_addr;
  thi_pkg::bank_data_t             rd_data;
  thi_pkg::lookup_t                lookup;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign query_acc = accept && (item_i.cmd == thi_pkg::CMD_QUERY);
  assign write_acc = accept && (item_i.cmd == thi_pkg::CMD_WRITE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= '0;
      grid_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thi_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        thi_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A write goes to the bank chosen by the parities of its column and row.
  assign wr_addr = {item_i.cell_row[thi_pkg::ROW_W-1:1],
                    item_i.cell_col[thi_pkg::COL_W-1:1]};

  always_comb begin
    for (int b = 0; b < thi_pkg::NUM_BANKS; b++) begin
      bank_we[b] = write_acc &&
                   ({item_i.cell_row[0], item_i.cell_col[0]} == 2'(b));
    end
  end

  thi_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_i       (query_acc),
    .point_x_i     (item_i.point_x),
    .point_y_i     (item_i.point_y),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .lookup_o      (lookup)
  );

  for (genvar g = 0; g < thi_pkg::NUM_BANKS; g++) begin : g_bank
    thi_ram #(
      .WIDTH (thi_pkg::CODE_W),
      .DEPTH (thi_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (wr_addr),
      .wdata_i (item_i.height_code),
      .re_i    (rd_en),
      .raddr_i (rd_addr[g]),
      .rdata_o (rd_data[g])
    );
  end

  thi_interp u_interp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lookup_i       (lookup),
    .rd_data_i      (rd_data),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  // Every query transfer yields a result strobe.
  a_query_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |-> ##5 result_valid_o)
    else $error("query transfer without matching result");

  // No result strobe appears without a matching earlier query transfer.
  a_result_from_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(query_acc, 5))
    else $error("result strobe without query transfer");

  // An out-of-range result carries a zero height.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.sample_valid) |-> (result_o.height_hundredths == '0))
    else $error("invalid sample with non-zero height");

  // A write touches at most one bank.
  a_one_bank_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("write enables more than one bank");
`endif

endmodule

`default_nettype wire

// ===== rtl/thi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read. A read of the
// address being written in the same cycle returns the old contents.
module thi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/thi_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Query front end: splits the point into grid square and fraction, checks the
// range and issues one read to each bank.
module thi_addr (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          query_i,
  input  wire logic [thi_pkg::POINT_W-1:0]   point_x_i,
  input  wire logic [thi_pkg::POINT_W-1:0]   point_y_i,
  input  wire logic [thi_pkg::DIM_W-1:0]     grid_width_i,
  input  wire logic [thi_pkg::DIM_W-1:0]     grid_height_i,
  output      logic                          rd_en_o,
  output      thi_pkg::bank_addr_t           rd_addr_o,
  output      thi_pkg::lookup_t              lookup_o
);

  logic                        q1_vld_q;
  logic [thi_pkg::POINT_W-1:0] x_q, y_q;

  logic [thi_pkg::PROD_W-1:0]  x_prod, y_prod;
  logic [thi_pkg::TILE_W-1:0]  tx, ty;
  logic [thi_pkg::FRAC_W-1:0]  fx, fy;
  logic [thi_pkg::DIM_W-1:0]   w_sat, h_sat;
  logic                        in_range;

  thi_pkg::lookup_t lookup_d, lookup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
    end else begin
      q1_vld_q <= query_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_i) begin
      x_q <= point_x_i;
      y_q <= point_y_i;
    end
  end

  // Division by the grid spacing as a multiply by its reciprocal; exact for
  // every 15-bit coordinate.
  always_comb begin
    x_prod = thi_pkg::PROD_W'(x_q) * thi_pkg::PROD_W'(thi_pkg::RECIP);
    y_prod = thi_pkg::PROD_W'(y_q) * thi_pkg::PROD_W'(thi_pkg::RECIP);
    tx     = x_prod[thi_pkg::RECIP_SHIFT +: thi_pkg::TILE_W];
    ty     = y_prod[thi_pkg::RECIP_SHIFT +: thi_pkg::TILE_W];
    fx     = thi_pkg::FRAC_W'(x_q - thi_pkg::POINT_W'(
               thi_pkg::POINT_W'(tx) * thi_pkg::POINT_W'(thi_pkg::SPACING)));
    fy     = thi_pkg::FRAC_W'(y_q - thi_pkg::POINT_W'(
               thi_pkg::POINT_W'(ty) * thi_pkg::POINT_W'(thi_pkg::SPACING)));
  end

  // A point is inside when its square index lies below the last grid line.
  always_comb begin
    w_sat = (grid_width_i > thi_pkg::DIM_W'(thi_pkg::MAX_COLS)) ?
            thi_pkg::DIM_W'(thi_pkg::MAX_COLS) : grid_width_i;
    h_sat = (grid_height_i > thi_pkg::DIM_W'(thi_pkg::MAX_ROWS)) ?
            thi_pkg::DIM_W'(thi_pkg::MAX_ROWS) : grid_height_i;
    in_range = (w_sat >= thi_pkg::DIM_W'(2)) && (h_sat >= thi_pkg::DIM_W'(2)) &&
               (tx < w_sat - thi_pkg::DIM_W'(1)) && (ty < h_sat - thi_pkg::DIM_W'(1));
  end

  // Each bank holds one column parity and one row parity; pick the corner
  // of the square that matches.
  always_comb begin
    logic [1:0]                 bid;
    logic [thi_pkg::COL_W-1:0]  col;
    logic [thi_pkg::ROW_W-1:0]  row;
    for (int b = 0; b < thi_pkg::NUM_BANKS; b++) begin
      bid = 2'(b);
      col = (tx[0] == bid[0]) ? tx[thi_pkg::COL_W-1:0] :
            tx[thi_pkg::COL_W-1:0] + thi_pkg::COL_W'(1);
      row = (ty[0] == bid[1]) ? ty[thi_pkg::ROW_W-1:0] :
            ty[thi_pkg::ROW_W-1:0] + thi_pkg::ROW_W'(1);
      rd_addr_o[b] = {row[thi_pkg::ROW_W-1:1], col[thi_pkg::COL_W-1:1]};
    end
  end

  always_comb begin
    lookup_d.vld      = q1_vld_q;
    lookup_d.in_range = in_range;
    lookup_d.tx_odd   = tx[0];
    lookup_d.ty_odd   = ty[0];
    lookup_d.fx       = fx;
    lookup_d.fy       = fy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_q <= '0;
    end else begin
      lookup_q <= lookup_d;
    end
  end

  assign rd_en_o  = q1_vld_q;
  assign lookup_o = lookup_q;

endmodule

`default_nettype wire

// ===== rtl/thi_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Triangle interpolation over three register stages: corner selection and
// differences, products, then sum, scaling to hundredths and clamping.
module thi_interp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire thi_pkg::lookup_t    lookup_i,
  input  wire thi_pkg::bank_data_t rd_data_i,
  output      logic                result_valid_o,
  output      thi_pkg::result_t    result_o
);

  localparam int DW = thi_pkg::CODE_W + 1;
  localparam int PW = 17;
  localparam int SW = PW + 1;
  localparam int RW = SW + 4;

  // Stage A: corners and differences in height codes.
  logic [thi_pkg::CODE_W-1:0] tl, tr, bl, br;
  logic                       upper;
  logic signed [DW-1:0]       base_d, d1_d, d2_d;
  logic [thi_pkg::FRAC_W-1:0] f1_d, f2_d;

  logic                       a_vld_q, a_in_q;
  logic signed [DW-1:0]       a_base_q, a_d1_q, a_d2_q;
  logic [thi_pkg::FRAC_W-1:0] a_f1_q, a_f2_q;

  // Stage B: products.
  logic signed [PW-1:0]       bsc_d, p1_d, p2_d;
  logic                       b_vld_q, b_in_q;
  logic signed [PW-1:0]       b_bsc_q, b_p1_q, b_p2_q;

  // Stage C: result.
  logic signed [SW-1:0]       sum;
  logic signed [RW-1:0]       r10;
  thi_pkg::result_t           res_d, res_q;
  logic                       res_vld_q;

  always_comb begin
    tl = rd_data_i[{lookup_i.ty_odd,  lookup_i.tx_odd}];
    tr = rd_data_i[{lookup_i.ty_odd, ~lookup_i.tx_odd}];
    bl = rd_data_i[{~lookup_i.ty_odd, lookup_i.tx_odd}];
    br = rd_data_i[{~lookup_i.ty_odd, ~lookup_i.tx_odd}];
    upper = ((thi_pkg::FRAC_W + 1)'(lookup_i.fx) + (thi_pkg::FRAC_W + 1)'(lookup_i.fy))
            <= (thi_pkg::FRAC_W + 1)'(thi_pkg::SPACING);
    if (upper) begin
      base_d = $signed({1'b0, tl}) - $signed(DW'(thi_pkg::CODE_ZERO));
      d1_d   = $signed({1'b0, tr}) - $signed({1'b0, tl});
      d2_d   = $signed({1'b0, bl}) - $signed({1'b0, tl});
      f1_d   = lookup_i.fx;
      f2_d   = lookup_i.fy;
    end else begin
      base_d = $signed({1'b0, br}) - $signed(DW'(thi_pkg::CODE_ZERO));
      d1_d   = $signed({1'b0, bl}) - $signed({1'b0, br});
      d2_d   = $signed({1'b0, tr}) - $signed({1'b0, br});
      f1_d   = thi_pkg::FRAC_W'(thi_pkg::SPACING) - lookup_i.fx;
      f2_d   = thi_pkg::FRAC_W'(thi_pkg::SPACING) - lookup_i.fy;
    end
  end

  always_comb begin
    bsc_d = $signed({{(PW-DW){a_base_q[DW-1]}}, a_base_q})
            * $signed(PW'(thi_pkg::SPACING));
    p1_d  = $signed({{(PW-thi_pkg::FRAC_W){1'b0}}, a_f1_q})
            * $signed({{(PW-DW){a_d1_q[DW-1]}}, a_d1_q});
    p2_d  = $signed({{(PW-thi_pkg::FRAC_W){1'b0}}, a_f2_q})
            * $signed({{(PW-DW){a_d2_q[DW-1]}}, a_d2_q});
  end

  always_comb begin
    sum = $signed({b_bsc_q[PW-1], b_bsc_q}) + $signed({b_p1_q[PW-1], b_p1_q})
          + $signed({b_p2_q[PW-1], b_p2_q});
    r10 = $signed({{(RW-SW){sum[SW-1]}}, sum}) * $signed(RW'(thi_pkg::CM_PER_CODE));
    res_d.sample_valid = b_in_q;
    if (!b_in_q || r10[RW-1]) begin
      res_d.height_hundredths = '0;
    end else begin
      res_d.height_hundredths = r10[thi_pkg::HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= lookup_i.vld;
      b_vld_q   <= a_vld_q;
      res_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_in_q   <= lookup_i.in_range;
    a_base_q <= base_d;
    a_d1_q   <= d1_d;
    a_d2_q   <= d2_d;
    a_f1_q   <= f1_d;
    a_f2_q   <= f2_d;
    b_in_q   <= a_in_q;
    b_bsc_q  <= bsc_d;
    b_p1_q   <= p1_d;
    b_p2_q   <= p2_d;
    res_q    <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire
